// File: rtl/ntp_pkg.sv
// Shared types and constants for the noisy tile pixel generator.
package ntp_pkg;

  localparam int unsigned TILE_SIDE_DEF = 16;

  localparam logic [31:0] RNG_SEED = 32'h9E37_79B9;
  localparam int unsigned SHIFT_A = 13;
  localparam int unsigned SHIFT_B = 17;
  localparam int unsigned SHIFT_C = 5;

  localparam int unsigned DIV_W   = 7;
  localparam int unsigned DVD_W   = 32;
  localparam logic [DIV_W-1:0] AMP_MOD  = 7'd17;
  localparam logic [DIV_W-1:0] SIGN_MOD = 7'd3;
  localparam logic [4:0]       AMP_BIAS = 5'd8;

  // Fixed moduli: byte fold, then reciprocal multiply on the small sum.
  localparam int unsigned FOLD_W     = 10;
  localparam logic [7:0]  AMP_RECIP  = 8'd241;   // ceil(2^12 / 17)
  localparam int unsigned AMP_RSH    = 12;
  localparam logic [9:0]  SIGN_RECIP = 10'd683;  // ceil(2^11 / 3)
  localparam int unsigned SIGN_RSH   = 11;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_RED      = 3'd0,
    REG_BASE_GREEN    = 3'd1,
    REG_BASE_BLUE     = 3'd2,
    REG_NOISE_LIMIT   = 3'd3,
    REG_SPECKLE_LEVEL = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]       base_red;
    logic [7:0]       base_green;
    logic [7:0]       base_blue;
    logic [DIV_W-1:0] noise_limit;
    logic [DIV_W-1:0] speckle_level;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] rem;
  } mod_rsp_t;

  function automatic logic [31:0] xorshift32(input logic [31:0] x);
    logic [31:0] t;
    t = x ^ (x << SHIFT_A);
    t = t ^ (t >> SHIFT_B);
    t = t ^ (t << SHIFT_C);
    return t;
  endfunction

  // 256 is 1 modulo both 17 and 3, so the byte sum keeps the remainder.
  function automatic logic [FOLD_W-1:0] byte_fold(input logic [31:0] x);
    return {2'b00, x[31:24]} + {2'b00, x[23:16]} + {2'b00, x[15:8]} + {2'b00, x[7:0]};
  endfunction

  // Quotient estimate is exact for sums below 4096.
  function automatic logic [4:0] fold_mod17(input logic [FOLD_W-1:0] s);
    logic [17:0]       prod;
    logic [5:0]        quo;
    logic [FOLD_W-1:0] back;
    logic [FOLD_W-1:0] rem;
    prod = {8'd0, s} * {10'd0, AMP_RECIP};
    quo  = 6'(prod >> AMP_RSH);
    back = {4'd0, quo} * {3'd0, AMP_MOD};
    rem  = s - back;
    return rem[4:0];
  endfunction

  // Quotient estimate is exact for sums below 2048.
  function automatic logic [1:0] fold_mod3(input logic [FOLD_W-1:0] s);
    logic [19:0]       prod;
    logic [8:0]        quo;
    logic [FOLD_W-1:0] back;
    logic [FOLD_W-1:0] rem;
    prod = {10'd0, s} * {10'd0, SIGN_RECIP};
    quo  = 9'(prod >> SIGN_RSH);
    back = {1'b0, quo} * {3'd0, SIGN_MOD};
    rem  = s - back;
    return rem[1:0];
  endfunction

endpackage

// File: rtl/ntp_channels.sv
// Valid/ready channel interfaces: request, pixel result and register write.
interface ntp_in_if;
  logic valid;
  logic ready;
  logic advance;
  modport source(output valid, output advance, input ready);
  modport sink(input valid, input advance, output ready);
endinterface

interface ntp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel;
  logic        last_pixel;
  modport source(output valid, output pixel, output last_pixel, input ready);
  modport sink(input valid, input pixel, input last_pixel, output ready);
endinterface

interface ntp_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ntp_pkg::CFG_IDX_W-1:0]   index;
  logic [ntp_pkg::CFG_DATA_W-1:0]  data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

// File: rtl/ntp_cfg_regs.sv
// Configuration register file written over the cfg channel.
module ntp_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  ntp_cfg_if.sink       cfg_ch,
  output ntp_pkg::cfg_t cfg_o
);

  ntp_pkg::cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg_o        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_red      <= 8'd0;
      cfg_r.base_green    <= 8'd0;
      cfg_r.base_blue     <= 8'd0;
      cfg_r.noise_limit   <= 7'd4;
      cfg_r.speckle_level <= 7'd3;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        ntp_pkg::REG_BASE_RED:      cfg_r.base_red      <= cfg_ch.data;
        ntp_pkg::REG_BASE_GREEN:    cfg_r.base_green    <= cfg_ch.data;
        ntp_pkg::REG_BASE_BLUE:     cfg_r.base_blue     <= cfg_ch.data;
        ntp_pkg::REG_NOISE_LIMIT:   cfg_r.noise_limit   <= cfg_ch.data[ntp_pkg::DIV_W-1:0];
        ntp_pkg::REG_SPECKLE_LEVEL: cfg_r.speckle_level <= cfg_ch.data[ntp_pkg::DIV_W-1:0];
        default: ; // unmapped index, write dropped
      endcase
    end
  end

endmodule

// File: rtl/ntp_mod_unit.sv
// Bit-serial restoring remainder unit, one dividend bit per cycle.
module ntp_mod_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  ntp_pkg::mod_req_t req_i,
  output ntp_pkg::mod_rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(ntp_pkg::DVD_W);

  logic [ntp_pkg::DVD_W-1:0] dvd_r;
  logic [ntp_pkg::DIV_W-1:0] div_r;
  logic [ntp_pkg::DIV_W-1:0] rem_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      busy_r;
  logic                      done_r;
  logic [ntp_pkg::DIV_W:0]   trial;
  logic [ntp_pkg::DIV_W:0]   rem_nxt;

  always_comb begin
    trial = {rem_r, dvd_r[ntp_pkg::DVD_W-1]};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = trial - {1'b0, div_r};
    end else begin
      rem_nxt = trial;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req_i.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ntp_pkg::DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_i.start) begin
      dvd_r <= req_i.dividend;
      div_r <= req_i.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[ntp_pkg::DVD_W-2:0], 1'b0};
      rem_r <= rem_nxt[ntp_pkg::DIV_W-1:0];
    end
  end

  assign rsp_o.busy = busy_r;
  assign rsp_o.done = done_r;
  assign rsp_o.rem  = rem_r;

endmodule

// File: rtl/ntp_pixel_pack.sv
// Applies the signed offset to each base channel, clamps and packs RGB565.
module ntp_pixel_pack (
  input  ntp_pkg::cfg_t              cfg_i,
  input  logic [ntp_pkg::DIV_W-1:0]  amp_i,
  input  logic                       pos_i,
  input  logic                       neg_i,
  output logic [15:0]                pixel_o
);

  function automatic logic [7:0] offset_clamp(input logic [7:0] base,
                                              input logic [ntp_pkg::DIV_W-1:0] amp,
                                              input logic pos, input logic neg);
    logic [8:0] sum;
    logic [8:0] dif;
    logic [7:0] res;
    sum = {1'b0, base} + {2'b00, amp};
    dif = {1'b0, base} - {2'b00, amp};
    res = base;
    if (pos) begin
      res = sum[8] ? 8'hFF : sum[7:0];
    end else if (neg) begin
      res = dif[8] ? 8'h00 : dif[7:0];
    end
    return res;
  endfunction

  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  assign red     = offset_clamp(cfg_i.base_red,   amp_i, pos_i, neg_i);
  assign green   = offset_clamp(cfg_i.base_green, amp_i, pos_i, neg_i);
  assign blue    = offset_clamp(cfg_i.base_blue,  amp_i, pos_i, neg_i);
  assign pixel_o = {red[7:3], green[7:2], blue[7:3]};

endmodule

// File: rtl/noisy_tile_pixel_generator.sv
// Top level of the noisy tile pixel generator: sequencer, generator and output register.
//
// Usage:
//   in_ch   request channel; one transaction with advance = 1 asks for the next
//           pixel of the tile in raster order. A transaction with advance = 0 is
//           taken and dropped, giving no result.
//   out_ch  result channel; one transaction per pixel: RGB565 word plus
//           last_pixel, high on pixel TILE_SIDE*TILE_SIDE-1 of each tile.
//   cfg_ch  register write channel, always ready; write only while idle.
// Timing: each pixel needs two or three xorshift32 draws. The mod 17 and mod 3
//   draws each step through draw + byte fold, reciprocal and evaluate; the
//   speckle draw goes through the bit-serial remainder unit (32 steps). The
//   result is held in the output register, and the speckle remainder is
//   skipped when the speckle level is zero. A new request is taken only once
//   the sequencer is back in idle, after its pixel is loaded. The 32-step
//   remainder loop sets the worst case.
// Reset: generator reloads its seed, the tile position returns to 0 and the
//   configuration registers take their reset values; no result is pending.
// Stall: the finished pixel sits in the output register; a new request is
//   accepted meanwhile, and the sequencer holds a second pixel at its final
//   step until the output register frees up.
module noisy_tile_pixel_generator #(
  parameter int unsigned TILE_SIDE = ntp_pkg::TILE_SIDE_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ntp_in_if.sink    in_ch,
  ntp_out_if.source out_ch,
  ntp_cfg_if.sink   cfg_ch
);

  localparam int unsigned TOTAL = TILE_SIDE * TILE_SIDE;
  localparam int unsigned CNT_W = $clog2(TOTAL);
  localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(TOTAL - 1);
  localparam int unsigned AW = ntp_pkg::DIV_W;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DRAW = 6'b000010,
    S_FOLD = 6'b000100,
    S_DIV  = 6'b001000,
    S_EVAL = 6'b010000,
    S_PACK = 6'b100000
  } state_t;

  typedef enum logic [1:0] {
    PH_AMP     = 2'd0,
    PH_SIGN    = 2'd1,
    PH_SPECKLE = 2'd2
  } phase_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  ntp_pkg::cfg_t     cfg;
  ntp_pkg::mod_req_t mod_req;
  ntp_pkg::mod_rsp_t mod_rsp;

  logic [31:0]      rng_r, rng_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [AW-1:0]    amp_r, amp_nxt;
  logic             pos_r, pos_nxt;
  logic             neg_r, neg_nxt;
  logic             zero_draw_r;
  logic [ntp_pkg::FOLD_W-1:0] fold_r;
  logic [4:0]       cst_rem_r;
  logic [31:0]      draw;
  logic             skip_div;
  logic [4:0]       amp_raw;
  logic             speck_hit;
  logic [15:0]      pixel;
  logic             load_out;

  logic        out_valid_r;
  logic [15:0] out_pixel_r;
  logic        out_last_r;

  ntp_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg_o  (cfg)
  );

  ntp_mod_unit u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (mod_req),
    .rsp_o (mod_rsp)
  );

  ntp_pixel_pack u_pack (
    .cfg_i   (cfg),
    .amp_i   (amp_r),
    .pos_i   (pos_r),
    .neg_i   (neg_r),
    .pixel_o (pixel)
  );

  assign draw     = ntp_pkg::xorshift32(rng_r);
  // Zero speckle level: remainder is the draw itself, so only a zero draw hits.
  assign skip_div = (phase_r == PH_SPECKLE) && (cfg.speckle_level == '0);
  assign load_out = (state_r == S_PACK) && (!out_valid_r || out_ch.ready);

  // |rem - 8| for the amplitude draw; rem stays below 17
  always_comb begin
    if (cst_rem_r >= ntp_pkg::AMP_BIAS) begin
      amp_raw = cst_rem_r - ntp_pkg::AMP_BIAS;
    end else begin
      amp_raw = ntp_pkg::AMP_BIAS - cst_rem_r;
    end
  end

  assign speck_hit = (cfg.speckle_level == '0) ? zero_draw_r : (mod_rsp.rem == '0);

  always_comb begin
    mod_req.start    = 1'b0;
    mod_req.dividend = draw;
    mod_req.divisor  = cfg.speckle_level;

    state_nxt = state_r;
    phase_nxt = phase_r;
    rng_nxt   = rng_r;
    amp_nxt   = amp_r;
    pos_nxt   = pos_r;
    neg_nxt   = neg_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid && in_ch.advance) begin
          state_nxt = S_DRAW;
          phase_nxt = PH_AMP;
        end
      end
      S_DRAW: begin
        rng_nxt = draw;
        if (phase_r != PH_SPECKLE) begin
          state_nxt = S_FOLD;
        end else if (skip_div) begin
          state_nxt = S_EVAL;
        end else begin
          mod_req.start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_FOLD: begin
        state_nxt = S_EVAL;
      end
      S_DIV: begin
        if (mod_rsp.done) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        unique case (phase_r)
          PH_AMP: begin
            amp_nxt   = ({2'b00, amp_raw} > cfg.noise_limit) ? '0 : {2'b00, amp_raw};
            phase_nxt = PH_SIGN;
            state_nxt = S_DRAW;
          end
          PH_SIGN: begin
            // remainder 0, 1, 2 maps to sign -1, 0, +1
            neg_nxt = (cst_rem_r == '0);
            pos_nxt = (cst_rem_r == 5'd2);
            if (cst_rem_r == 5'd2) begin
              phase_nxt = PH_SPECKLE;
              state_nxt = S_DRAW;
            end else begin
              state_nxt = S_PACK;
            end
          end
          default: begin
            if (speck_hit) begin
              amp_nxt = cfg.speckle_level;
            end
            state_nxt = S_PACK;
          end
        endcase
      end
      S_PACK: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ch.ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_AMP;
      rng_r       <= ntp_pkg::RNG_SEED;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      rng_r   <= rng_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
        cnt_r       <= (cnt_r == LAST_POS) ? '0 : cnt_r + 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    amp_r <= amp_nxt;
    pos_r <= pos_nxt;
    neg_r <= neg_nxt;
    if (state_r == S_DRAW) begin
      zero_draw_r <= (draw == '0);
      fold_r      <= ntp_pkg::byte_fold(draw);
    end
    // fixed modulus of the folded draw: 17 for amplitude, 3 for sign
    if (state_r == S_FOLD) begin
      cst_rem_r <= (phase_r == PH_AMP) ? ntp_pkg::fold_mod17(fold_r)
                                       : {3'b000, ntp_pkg::fold_mod3(fold_r)};
    end
    if (load_out) begin
      out_pixel_r <= pixel;
      out_last_r  <= (cnt_r == LAST_POS);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pixel      = out_pixel_r;
  assign out_ch.last_pixel = out_last_r;

  // a request with advance set always starts the amplitude draw
  a_start_draw: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.advance |=> state_r == S_DRAW && phase_r == PH_AMP)
    else $error("request did not start the amplitude draw");

  // the remainder unit is busy or finishing whenever the sequencer waits on it
  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> mod_rsp.busy || mod_rsp.done)
    else $error("sequencer waiting on an idle remainder unit");

  // generator advances only on a draw step
  a_rng_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(state_r != S_DRAW) |-> rng_r == $past(rng_r))
    else $error("generator state moved outside a draw");

  // tile position wraps after the flagged last pixel
  a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    load_out && cnt_r == LAST_POS |=> cnt_r == '0 && out_ch.last_pixel)
    else $error("tile position did not wrap on the last pixel");

  // a new result appears only out of the pack step
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(out_valid_r) |-> $past(state_r == S_PACK))
    else $error("result appeared outside the pack step");

endmodule
